[hw/rtl/gtk_pkg.sv]
// Shared types and constants of the grouped top-k selector.
// Used by gtk_ctrl, gtk_datapath, the top level and the checker.
`timescale 1ns / 1ps
package gtk_pkg;

  localparam int MAX_K  = 16;
  localparam int DATA_W = 32;
  localparam int TOPK_W = 5;
  localparam int CW     = $clog2(MAX_K + 1);             // holds 0..MAX_K
  localparam int IW     = (MAX_K > 1) ? $clog2(MAX_K) : 1; // index of a kept entry

  localparam logic [TOPK_W-1:0] TOPK_RESET = TOPK_W'(16);

  // tuser codes on the input side
  localparam logic REQ_ENTRY = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] freq;
    logic [DATA_W-1:0] tag;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic ins_in;  // insert the input entry into the open group
    logic cap;     // hold the input word and load the emit count
    logic pop;     // move the best kept entry to the output register
    logic fin;     // close the drained group, open the held one if any
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic open;
    logic key_eq;
    logic rem_zero;
    logic rem_one;
    logic slot_free;
  } sts_t;

endpackage

[hw/rtl/gtk_ctrl.sv]
// Controller of the grouped top-k selector: run, drain and reopen sequencing.
// Depends on gtk_pkg.
`timescale 1ns / 1ps
module gtk_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,
  input  gtk_pkg::sts_t sts,
  output logic          s_tready,
  output gtk_pkg::cmd_t cmd
);
  import gtk_pkg::*;

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_FLUSH) begin
            if (sts.open) begin
              cmd.cap    = 1'b1;
              state_next = S_EMIT;
            end
          end else if (sts.open && !sts.key_eq) begin
            cmd.cap    = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.ins_in = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (sts.rem_zero) begin
          state_next = S_FIN;
        end else if (sts.slot_free) begin
          cmd.pop = 1'b1;
          if (sts.rem_one) state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_RUN;
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_RUN);

endmodule

[hw/rtl/gtk_datapath.sv]
// Datapath of the grouped top-k selector: sorted entry cells, group registers,
// held word and output register. Depends on gtk_pkg.
`timescale 1ns / 1ps
module gtk_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [3*gtk_pkg::DATA_W-1:0]      s_tdata,
  input  logic                              s_tuser,
  input  logic                              cfg_valid,
  input  logic [gtk_pkg::TOPK_W-1:0]        cfg_data,
  input  gtk_pkg::cmd_t                     cmd,
  output gtk_pkg::sts_t                     sts,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [3*gtk_pkg::DATA_W-1:0]      m_tdata,
  output logic                              m_tlast
);
  import gtk_pkg::*;

  logic [DATA_W-1:0] in_key, in_tag, in_freq;
  assign in_key  = s_tdata[DATA_W-1:0];
  assign in_tag  = s_tdata[2*DATA_W-1:DATA_W];
  assign in_freq = s_tdata[3*DATA_W-1:2*DATA_W];

  entry_t            cells [MAX_K];
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] cur_key;
  logic              open;
  logic [CW-1:0]     rem;
  logic [TOPK_W-1:0] top_k;
  logic              pend_flush;
  logic [DATA_W-1:0] pend_key, pend_tag, pend_freq;
  logic [DATA_W-1:0] out_key, out_tag, out_freq;

  logic [CW-1:0] lim;
  logic [CW-1:0] emit_n;
  always_comb begin
    if (int'(top_k) > MAX_K) lim = CW'(MAX_K);
    else                     lim = CW'(top_k);
    emit_n = (count > lim) ? lim : count;
  end

  // sorted insertion, all cells compared at once
  logic              do_ins;
  logic [DATA_W-1:0] src_tag, src_freq;
  entry_t            src_e;
  logic [CW-1:0]     base, cnt_t, ins_count;
  logic [MAX_K-1:0]  ge;
  logic              drop;
  entry_t            ins_cells [MAX_K];

  always_comb begin
    do_ins   = cmd.ins_in || (cmd.fin && !pend_flush);
    src_tag  = cmd.fin ? pend_tag  : in_tag;
    src_freq = cmd.fin ? pend_freq : in_freq;
    src_e    = '{freq: src_freq, tag: src_tag};
    base     = (cmd.fin || !open) ? '0 : count;
    cnt_t    = (base > lim) ? lim : base;
    for (int i = 0; i < MAX_K; i++) begin
      ge[i] = (CW'(i) < cnt_t) && (cells[i].freq >= src_freq);
    end
    // a full list drops a newcomer that no kept entry ranks below
    drop = (lim == '0) || ((cnt_t == lim) && ge[IW'(lim - 1'b1)]);
    if (drop)            ins_count = cnt_t;
    else if (cnt_t < lim) ins_count = cnt_t + 1'b1;
    else                 ins_count = cnt_t;
    ins_cells[0] = ge[0] ? cells[0] : src_e;
    for (int i = 1; i < MAX_K; i++) begin
      if (ge[i]) begin
        ins_cells[i] = cells[i];
      end else if (ge[i-1]) begin
        ins_cells[i] = src_e;
      end else begin
        ins_cells[i] = cells[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cur_key  <= '0;
      open     <= 1'b0;
      rem      <= '0;
      top_k    <= TOPK_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) top_k <= cfg_data;
      if (cmd.ins_in) begin
        cur_key <= in_key;
        open    <= 1'b1;
      end
      if (cmd.cap) rem <= emit_n;
      if (cmd.pop) begin
        rem      <= rem - 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (do_ins) count <= ins_count;
      if (cmd.fin) begin
        if (pend_flush) begin
          open  <= 1'b0;
          count <= '0;
        end else begin
          cur_key <= pend_key;
          open    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins && !drop) begin
      for (int i = 0; i < MAX_K; i++) cells[i] <= ins_cells[i];
    end else if (cmd.pop) begin
      for (int i = 0; i < MAX_K - 1; i++) cells[i] <= cells[i+1];
    end
    if (cmd.cap) begin
      pend_flush <= (s_tuser == REQ_FLUSH);
      pend_key   <= in_key;
      pend_tag   <= in_tag;
      pend_freq  <= in_freq;
    end
    if (cmd.pop) begin
      out_key  <= cur_key;
      out_tag  <= cells[0].tag;
      out_freq <= cells[0].freq;
      m_tlast  <= (rem == CW'(1));
    end
  end

  assign m_tdata = {out_freq, out_tag, out_key};

  always_comb begin
    sts.open      = open;
    sts.key_eq    = (in_key == cur_key);
    sts.rem_zero  = (rem == '0);
    sts.rem_one   = (rem == CW'(1));
    sts.slot_free = !m_tvalid || m_tready;
  end

endmodule

[hw/rtl/grouped_top_k_selector.sv]
// Top level of the grouped top-k selector: controller plus datapath.
// Depends on gtk_pkg, gtk_ctrl and gtk_datapath.
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tdata key,tag,freq; s_tuser req_type
//  m       | out | m_tvalid/m_tready  | m_tdata key,tag,freq; m_tlast last_of_group
//  cfg     | in  | cfg_valid/cfg_ready| cfg_data top_k
//
// Entries of the open group are taken one per cycle; sorted insertion into the
// kept list happens in the accepting cycle across all cells in parallel.
// A key change or flush with an open group stalls input while the kept list
// drains through the output register, one word per cycle while downstream is
// ready, and while the group is then closed and the held word is taken in.
// Synchronous reset clears group state, output valid, and sets top_k to 16.
`timescale 1ns / 1ps
module grouped_top_k_selector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [3*gtk_pkg::DATA_W-1:0] s_tdata,  // group_key, entry_tag, frequency
  input  logic                         s_tuser,  // req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [3*gtk_pkg::DATA_W-1:0] m_tdata,  // out_key, out_tag, out_frequency
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gtk_pkg::TOPK_W-1:0]   cfg_data
);
  import gtk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gtk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  gtk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

[hw/rtl/gtk_checker.sv]
// Port-level checks of the grouped top-k selector, bound to the top level.
// Depends on gtk_pkg.
`timescale 1ns / 1ps
module gtk_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [3*gtk_pkg::DATA_W-1:0] m_tdata,
  input logic                         m_tlast
);

  // no word left over after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed under stall");

  // words only appear while a group drains, and input is held off then
  a_drain_stalls_in: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !s_tready)
    else $error("input taken while a group drains");

  // a freshly loaded last word ends the drain: input is free on the next cycle
  a_last_then_free: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && (!$past(m_tvalid) || $past(m_tready)) |=> s_tready)
    else $error("input stays blocked after last word");

endmodule

bind grouped_top_k_selector gtk_checker u_gtk_checker (.*);
